### hdl/svie_pkg.sv
// Shared types and constants for the stack machine execution unit.
`default_nettype none
package svie_pkg;

  localparam int DefRegCount = 16;
  localparam int DefRamBytes = 65536;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_LOW    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_HIGH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_START = 2'd2;

  localparam logic [15:0] RST_WIN_LOW    = 16'd32768;
  localparam logic [15:0] RST_WIN_HIGH   = 16'd65528;
  localparam logic [15:0] RST_CODE_START = 16'd0;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_HALT   = 3'd1;
  localparam logic [2:0] ST_ACCESS = 3'd2;
  localparam logic [2:0] ST_DIVZ   = 3'd3;
  localparam logic [2:0] ST_XCALL  = 3'd4;

  localparam logic [5:0] OP_NOP    = 6'd0;
  localparam logic [5:0] OP_HALT   = 6'd1;
  localparam logic [5:0] OP_CMP    = 6'd2;
  localparam logic [5:0] OP_CMPI   = 6'd3;
  localparam logic [5:0] OP_PUSH   = 6'd4;
  localparam logic [5:0] OP_PUSHI  = 6'd5;
  localparam logic [5:0] OP_POP    = 6'd6;
  localparam logic [5:0] OP_CALL   = 6'd7;
  localparam logic [5:0] OP_CALLI  = 6'd8;
  localparam logic [5:0] OP_CCALL  = 6'd9;
  localparam logic [5:0] OP_RET    = 6'd10;
  localparam logic [5:0] OP_MOV    = 6'd11;
  localparam logic [5:0] OP_MOVI   = 6'd12;
  localparam logic [5:0] OP_LEA    = 6'd13;
  localparam logic [5:0] OP_LEAI   = 6'd14;
  localparam logic [5:0] OP_LEAIP  = 6'd15;
  localparam logic [5:0] OP_LEAIPI = 6'd16;
  localparam logic [5:0] OP_LEASP  = 6'd17;
  localparam logic [5:0] OP_LEASPI = 6'd18;
  localparam logic [5:0] OP_STOSP  = 6'd19;
  localparam logic [5:0] OP_STOSPI = 6'd20;
  localparam logic [5:0] OP_LODSP  = 6'd21;
  localparam logic [5:0] OP_ADDSP  = 6'd22;
  localparam logic [5:0] OP_ADDSPI = 6'd23;
  localparam logic [5:0] OP_SUBSP  = 6'd24;
  localparam logic [5:0] OP_SUBSPI = 6'd25;
  localparam logic [5:0] OP_ADD    = 6'd26;
  localparam logic [5:0] OP_ADDI   = 6'd27;
  localparam logic [5:0] OP_SUB    = 6'd28;
  localparam logic [5:0] OP_SUBI   = 6'd29;
  localparam logic [5:0] OP_MUL    = 6'd30;
  localparam logic [5:0] OP_MULI   = 6'd31;
  localparam logic [5:0] OP_DIV    = 6'd32;
  localparam logic [5:0] OP_DIVI   = 6'd33;
  localparam logic [5:0] OP_AND    = 6'd34;
  localparam logic [5:0] OP_ANDI   = 6'd35;
  localparam logic [5:0] OP_OR     = 6'd36;
  localparam logic [5:0] OP_ORI    = 6'd37;
  localparam logic [5:0] OP_XOR    = 6'd38;
  localparam logic [5:0] OP_XORI   = 6'd39;
  localparam logic [5:0] OP_NOT    = 6'd40;
  localparam logic [5:0] OP_JMP    = 6'd41;
  localparam logic [5:0] OP_JE     = 6'd42;
  localparam logic [5:0] OP_JNE    = 6'd43;
  localparam logic [5:0] OP_JL     = 6'd44;
  localparam logic [5:0] OP_JG     = 6'd45;

  typedef struct packed {
    logic [5:0]         opcode;
    logic [3:0]         dest_index;
    logic [3:0]         source_index;
    logic [3:0]         base_index;
    logic [63:0]        immediate;
    logic signed [31:0] displacement;
    logic [3:0]         instr_length;
  } instr_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] next_ip;
    logic        reg_write_valid;
    logic [3:0]  reg_write_index;
    logic [63:0] reg_write_value;
    logic [15:0] stack_offset;
    logic [7:0]  call_slot;
  } result_t;

  typedef struct packed {
    logic accept;
    logic md_start;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic is_md;
    logic is_load;
    logic md_busy;
  } dp_stat_t;

endpackage
`default_nettype wire

### hdl/svie_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module svie_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### hdl/svie_muldiv.sv
// Iterative 64-bit multiplier (32x32 partial products) and restoring divider.
`default_nettype none
module svie_muldiv (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic        is_div,
  input  wire logic [63:0] a,
  input  wire logic [63:0] b,
  output logic             busy,
  output logic      [63:0] res
);

  logic        div_mode;
  logic [5:0]  cnt;
  logic [63:0] opa, opb, acc, prod, rem, quo;
  logic [31:0] mx, my;
  logic [64:0] trial;
  logic        fits;

  always_comb begin
    mx    = (cnt == 6'd2) ? opa[63:32] : opa[31:0];
    my    = (cnt == 6'd1) ? opb[63:32] : opb[31:0];
    trial = {rem, quo[63]};
    fits  = trial >= {1'b0, opb};
    res   = div_mode ? quo : acc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= !(is_div && (b == 64'd0));
    end else if (busy) begin
      if (div_mode ? (cnt == 6'd63) : (cnt == 6'd3)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      div_mode <= is_div;
      opa      <= a;
      opb      <= b;
      cnt      <= 6'd0;
      acc      <= 64'd0;
      rem      <= 64'd0;
      quo      <= a;
    end else if (busy) begin
      cnt <= cnt + 6'd1;
      if (div_mode) begin
        rem <= fits ? 64'(trial - {1'b0, opb}) : trial[63:0];
        quo <= {quo[62:0], fits};
      end else begin
        prod <= mx * my;
        if (cnt == 6'd1) begin
          acc <= acc + prod;
        end else if (cnt != 6'd0) begin
          acc <= acc + {prod[31:0], 32'd0};
        end
      end
    end
  end

endmodule
`default_nettype wire

### hdl/svie_dp.sv
// Datapath: register file, stack memory banks, machine state and result logic.
`default_nettype none
module svie_dp #(
  parameter int NUM_REGS  = 16,
  parameter int RAM_BYTES = 65536
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire svie_pkg::dp_cmd_t                  cmd,
  output svie_pkg::dp_stat_t                      stat,
  input  wire svie_pkg::instr_t                   instr,
  input  wire logic                               cfg_we,
  input  wire logic [svie_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [15:0]                        cfg_data,
  output svie_pkg::result_t                       result
);
  import svie_pkg::*;

  localparam int RIW   = $clog2(NUM_REGS);
  localparam int AW    = $clog2(RAM_BYTES);
  localparam int ROW_W = AW - 3;
  localparam int BANK_DEPTH = RAM_BYTES / 8;

  function automatic logic [3:0] reg_wrap(input logic [3:0] x);
    logic [3:0] r;
    r = x;
    for (int i = 0; i < 8; i++) begin
      if (int'(r) >= NUM_REGS) begin
        r = r - 4'(NUM_REGS);
      end
    end
    return r;
  endfunction

  // Configuration and architectural state.
  logic [15:0] win_low, win_high, code_start;
  logic [15:0] ip, sp;
  logic [63:0] cmp;
  logic [NUM_REGS-1:0] reg_valid;

  // Captured instruction.
  logic [5:0]  op;
  logic [3:0]  d4;
  logic [63:0] imm, disp;
  logic [3:0]  len;
  logic        vd, vs, vb;

  logic [63:0] rd_raw, rs_raw, rb_raw, rd, rs, rb;
  logic [63:0] md_res;
  logic        md_busy;

  logic [RIW-1:0] d_idx;
  logic [15:0] ipe, tgt, nip, nsp;
  logic [63:0] e64, sp64, opnd, a_push, a_pop, mem_a, ld_word, rd_word;
  logic [63:0] sum_sp, dif_sp, wval, ncmp, mem_wv;
  logic        win_ok, wr, mem_we, md_div;
  logic [2:0]  status, sh;
  logic [7:0]  slot;
  logic [ROW_W-1:0] row;
  logic [ROW_W-1:0] bank_addr [8];
  logic [7:0]       bank_wd [8];
  logic [7:0]       bank_rd [8];

  assign d_idx = RIW'(d4);

  // Register file: three copies give three read ports.
  svie_ram #(.WIDTH(64), .DEPTH(NUM_REGS)) u_rf_d (
    .clk, .we(cmd.commit && wr), .waddr(d_idx), .wdata(wval),
    .re(cmd.accept), .raddr(RIW'(reg_wrap(instr.dest_index))), .rdata(rd_raw)
  );
  svie_ram #(.WIDTH(64), .DEPTH(NUM_REGS)) u_rf_s (
    .clk, .we(cmd.commit && wr), .waddr(d_idx), .wdata(wval),
    .re(cmd.accept), .raddr(RIW'(reg_wrap(instr.source_index))), .rdata(rs_raw)
  );
  svie_ram #(.WIDTH(64), .DEPTH(NUM_REGS)) u_rf_b (
    .clk, .we(cmd.commit && wr), .waddr(d_idx), .wdata(wval),
    .re(cmd.accept), .raddr(RIW'(reg_wrap(instr.base_index))), .rdata(rb_raw)
  );

  // Stack memory: eight byte lanes, lane k holds byte addresses with low bits k.
  for (genvar k = 0; k < 8; k++) begin : g_bank
    svie_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_bank (
      .clk, .we(cmd.commit && mem_we), .waddr(bank_addr[k]), .wdata(bank_wd[k]),
      .re(1'b1), .raddr(bank_addr[k]), .rdata(bank_rd[k])
    );
  end

  svie_muldiv u_md (
    .clk, .rst, .start(cmd.md_start), .is_div(md_div), .a(rd), .b(opnd),
    .busy(md_busy), .res(md_res)
  );

  always_comb begin
    rd = vd ? rd_raw : 64'd0;
    rs = vs ? rs_raw : 64'd0;
    rb = vb ? rb_raw : 64'd0;

    ipe    = ip + 16'(len);
    e64    = {48'd0, ipe};
    tgt    = ipe + disp[15:0];
    sp64   = {48'd0, sp};
    opnd   = op[0] ? imm : rs;
    a_push = {48'd0, 16'(sp - 16'd8)};
    a_pop  = {48'd0, 16'(sp + 16'd8)} - 64'd8;
    sum_sp = sp64 + opnd;
    dif_sp = sp64 - opnd;
    md_div = (op == OP_DIV) || (op == OP_DIVI);

    if (op == OP_PUSH || op == OP_PUSHI || op == OP_CALL || op == OP_CALLI) begin
      mem_a = a_push;
    end else if (op == OP_POP || op == OP_RET) begin
      mem_a = a_pop;
    end else begin
      mem_a = sp64 + disp;
    end
    win_ok = (mem_a >= {48'd0, win_low}) && (mem_a <= {48'd0, win_high});

    sh  = mem_a[2:0];
    row = mem_a[AW-1:3];
    for (int k = 0; k < 8; k++) begin
      bank_addr[k] = row + ROW_W'(3'(k) < sh);
      bank_wd[k]   = mem_wv[{3'(3'(k) - sh), 3'b000} +: 8];
    end
    for (int i = 0; i < 8; i++) begin
      rd_word[8*i +: 8] = bank_rd[3'(3'(i) + sh)];
    end
    ld_word = win_ok ? rd_word : 64'd0;

    status = ST_OK;
    nip    = ipe;
    nsp    = sp;
    ncmp   = cmp;
    wr     = 1'b0;
    wval   = 64'd0;
    slot   = 8'd0;
    mem_we = 1'b0;
    if (op == OP_PUSHI || op == OP_STOSPI) begin
      mem_wv = imm;
    end else if (op == OP_PUSH || op == OP_STOSP) begin
      mem_wv = rs;
    end else begin
      mem_wv = e64;
    end

    case (op)
      OP_HALT: status = ST_HALT;
      OP_CMP:  ncmp = rd - rs;
      OP_CMPI: ncmp = rd - imm;
      OP_PUSH, OP_PUSHI: begin
        nsp = sp - 16'd8;
        mem_we = win_ok;
      end
      OP_POP: begin
        nsp = sp + 16'd8;
        wr = 1'b1;
        wval = ld_word;
      end
      OP_CALL: begin
        nsp = sp - 16'd8;
        mem_we = win_ok;
        nip = ipe + rs[15:0];
      end
      OP_CALLI: begin
        nsp = sp - 16'd8;
        mem_we = win_ok;
        nip = tgt;
      end
      OP_CCALL: begin
        status = ST_XCALL;
        slot = {4'd0, d4};
      end
      OP_RET: begin
        nsp = sp + 16'd8;
        nip = ld_word[15:0];
      end
      OP_MOV:    begin wr = 1'b1; wval = rs; end
      OP_MOVI:   begin wr = 1'b1; wval = imm; end
      OP_LEA:    begin wr = 1'b1; wval = rs + rb; end
      OP_LEAI:   begin wr = 1'b1; wval = rs + imm; end
      OP_LEAIP:  begin wr = 1'b1; wval = e64 + rs; end
      OP_LEAIPI: begin wr = 1'b1; wval = e64 + imm; end
      OP_LEASP:  begin wr = 1'b1; wval = sp64 + rs; end
      OP_LEASPI: begin wr = 1'b1; wval = sp64 + imm; end
      OP_STOSP, OP_STOSPI: begin
        mem_we = win_ok;
        status = win_ok ? ST_OK : ST_ACCESS;
      end
      OP_LODSP: begin wr = 1'b1; wval = ld_word; end
      OP_ADDSP, OP_ADDSPI: begin
        nsp = sum_sp[15:0];
        if (sum_sp > {48'd0, win_high}) status = ST_ACCESS;
      end
      OP_SUBSP, OP_SUBSPI: begin
        nsp = dif_sp[15:0];
        if (dif_sp < {48'd0, win_low}) status = ST_ACCESS;
      end
      OP_ADD, OP_ADDI: begin wr = 1'b1; wval = rd + opnd; end
      OP_SUB, OP_SUBI: begin wr = 1'b1; wval = rd - opnd; end
      OP_MUL, OP_MULI: begin wr = 1'b1; wval = md_res; end
      OP_DIV, OP_DIVI: begin
        if (opnd == 64'd0) begin
          status = ST_DIVZ;
        end else begin
          wr = 1'b1;
          wval = md_res;
        end
      end
      OP_AND, OP_ANDI: begin wr = 1'b1; wval = rd & opnd; end
      OP_OR, OP_ORI:   begin wr = 1'b1; wval = rd | opnd; end
      OP_XOR, OP_XORI: begin wr = 1'b1; wval = rd ^ opnd; end
      OP_NOT: begin wr = 1'b1; wval = ~rd; end
      OP_JMP: nip = tgt;
      OP_JE:  if (cmp == 64'd0) nip = tgt;
      OP_JNE: if (cmp != 64'd0) nip = tgt;
      OP_JL:  if (cmp[63]) nip = tgt;
      OP_JG:  if (!cmp[63] && (cmp != 64'd0)) nip = tgt;
      default: ;
    endcase

    stat.is_md   = (op == OP_MUL) || (op == OP_MULI) || md_div;
    stat.is_load = (op == OP_POP) || (op == OP_RET) || (op == OP_LODSP);
    stat.md_busy = md_busy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_low    <= RST_WIN_LOW;
      win_high   <= RST_WIN_HIGH;
      code_start <= RST_CODE_START;
      ip         <= RST_CODE_START;
      sp         <= RST_WIN_HIGH;
      cmp        <= 64'd0;
      reg_valid  <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_WIN_LOW:    win_low    <= cfg_data;
          CFG_WIN_HIGH:   win_high   <= cfg_data;
          CFG_CODE_START: code_start <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.commit) begin
        ip  <= nip;
        sp  <= nsp;
        cmp <= ncmp;
        if (wr) begin
          reg_valid[d_idx] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op   <= instr.opcode;
      d4   <= reg_wrap(instr.dest_index);
      imm  <= instr.immediate;
      disp <= 64'(instr.displacement);
      len  <= instr.instr_length;
      vd   <= reg_valid[RIW'(reg_wrap(instr.dest_index))];
      vs   <= reg_valid[RIW'(reg_wrap(instr.source_index))];
      vb   <= reg_valid[RIW'(reg_wrap(instr.base_index))];
    end
    if (cmd.commit) begin
      result.status          <= status;
      result.next_ip         <= nip;
      result.reg_write_valid <= wr;
      result.reg_write_index <= wr ? d4 : 4'd0;
      result.reg_write_value <= wr ? wval : 64'd0;
      result.stack_offset    <= nsp;
      result.call_slot       <= slot;
    end
  end

endmodule
`default_nettype wire

### hdl/svie_ctrl.sv
// Controller state machine: sequences accept, execute, multiply/divide wait, memory read and commit.
`default_nettype none
module svie_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               instr_valid,
  output logic                    instr_stall,
  output logic                    result_valid,
  input  wire logic               result_stall,
  input  wire svie_pkg::dp_stat_t stat,
  output svie_pkg::dp_cmd_t       cmd
);
  import svie_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_MD, S_MEM} state_t;

  state_t state, state_next;
  logic   out_free;

  always_comb begin
    out_free     = !result_valid || !result_stall;
    instr_stall  = (state != S_IDLE);
    cmd.accept   = (state == S_IDLE) && instr_valid;
    cmd.md_start = (state == S_EXEC) && stat.is_md;
    cmd.commit   = 1'b0;
    state_next   = state;
    unique case (state)
      S_IDLE: if (instr_valid) state_next = S_EXEC;
      S_EXEC: begin
        if (stat.is_md) begin
          state_next = S_MD;
        end else if (stat.is_load) begin
          state_next = S_MEM;
        end else if (out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_MD: begin
        if (!stat.md_busy && out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_MEM: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

`ifndef ASSERT_OFF
  a_commit_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> result_valid)
    else $error("committed beat did not reach the output");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |-> !cmd.commit)
    else $error("commit while output beat is stalled");
  a_accept_commit: assert property (@(posedge clk) disable iff (rst)
    !(cmd.accept && cmd.commit))
    else $error("accept and commit in one cycle");
  a_md_wait: assert property (@(posedge clk) disable iff (rst)
    cmd.md_start |=> (state == S_MD))
    else $error("divider started without waiting");
`endif

endmodule
`default_nettype wire

### hdl/stack_vm_instruction_execute.sv
// Top level of the stack machine instruction execution unit.
// Decoded instructions arrive as beats on the instr channel (instr_valid,
// instr_stall, instr) and each produces exactly one result beat on the result
// channel (result_valid, result_stall, result). A beat moves on a rising edge
// where valid is high and stall is low. Configuration registers (stack bottom,
// stack top, code start) are written through cfg_we, cfg_index and cfg_data.
// The user writes them only while the unit is idle; the block does not check.
// One instruction is in flight at a time. Most instructions commit in the
// execute state that follows accept (the registered register-file read),
// waiting there while the result is stalled, and the unit then returns to
// idle to take the next. Pop, ret and stack loads pass through a memory state
// for the registered stack-memory read. Multiply runs four steps on one 32x32
// multiplier, and divide runs a one-bit-per-cycle restoring divider; a divide
// by zero skips the divider.
// The result register parts the two sides: a new instruction is accepted while
// a finished result waits, and commit waits while the result is stalled.
// Reset (synchronous, active high) clears the registers to zero, sets the
// instruction pointer to the code start and the stack pointer to the stack top.
// Stack memory contents are not cleared.
`default_nettype none
module stack_vm_instruction_execute #(
  parameter int NUM_REGS  = svie_pkg::DefRegCount,
  parameter int RAM_BYTES = svie_pkg::DefRamBytes
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           instr_valid,
  output logic                                instr_stall,
  input  wire svie_pkg::instr_t               instr,
  output logic                                result_valid,
  input  wire logic                           result_stall,
  output svie_pkg::result_t                   result,
  input  wire logic                           cfg_we,
  input  wire logic [svie_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0]                    cfg_data
);
  import svie_pkg::*;

  // Commands flow from the controller, status back from the datapath.
  dp_cmd_t  cmd;
  dp_stat_t stat;

  svie_ctrl u_ctrl (
    .clk, .rst, .instr_valid, .instr_stall, .result_valid, .result_stall,
    .stat, .cmd
  );

  // The datapath holds all architectural state and the result register.
  svie_dp #(.NUM_REGS(NUM_REGS), .RAM_BYTES(RAM_BYTES)) u_dp (
    .clk, .rst, .cmd, .stat, .instr, .cfg_we, .cfg_index, .cfg_data, .result
  );

endmodule
`default_nettype wire
